// File: hdl/mdcvu_pkg.sv
// Shared types, codes and helper function of the microphone conditioner.
package mdcvu_pkg;

    localparam int unsigned WarmupWidth  = 16;
    localparam int unsigned GainWidth    = 4;
    localparam int unsigned SampleWidth  = 16;
    localparam int unsigned PeakWidth    = 15;
    localparam int unsigned VuWidth      = 4;
    localparam int unsigned FiltWidth    = 24;
    localparam int unsigned CfgDataWidth = 16;
    localparam int unsigned VuMax        = 10;
    localparam int unsigned VuStep       = 1600;

    localparam logic [GainWidth-1:0] GainReset = 4'd3;

    // Register indexes of the configuration port.
    localparam logic CFG_WARMUP_LENGTH = 1'b0;
    localparam logic CFG_MIC_GAIN      = 1'b1;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_DECAY   = 2'd1,
        OP_RESTART = 2'd2
    } t_op;

    typedef struct packed {
        t_op                            operation;
        logic signed [SampleWidth-1:0]  sample;
        logic                           last_in_chunk;
    } t_in_word;

    typedef struct packed {
        logic                           sample_valid;
        logic signed [SampleWidth-1:0]  conditioned_sample;
        logic [PeakWidth-1:0]           chunk_peak;
        logic [VuWidth-1:0]             vu_level;
    } t_out_word;

    // Peak / 1600 capped at 10, as a row of independent threshold compares.
    function automatic logic [VuWidth-1:0] vu_from_peak(input logic [PeakWidth-1:0] peak);
        logic [VuWidth-1:0] level;
        level = '0;
        for (int k = 1; k <= VuMax; k++) begin
            if ({1'b0, peak} >= (PeakWidth+1)'(k * VuStep)) begin
                level = VuWidth'(k);
            end
        end
        return level;
    endfunction

endpackage

// File: hdl/mic_dc_block_gain_vu_meter_core.sv
// Microphone conditioner top level: DC-blocking filter, gain, saturation, peak VU meter.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word) carries one word per
//   operation: a sample, a VU decay tick or a restart. Every accepted word
//   yields exactly one output word on o_out_valid / i_out_stall / o_out_word,
//   carrying the conditioned sample (when one is kept past warm-up), the
//   published chunk peak and the current VU level.
//   A word taken in sits in the input register, is processed by the filter,
//   gain multiplier and peak logic combinationally and lands in the output
//   register once that register is free or draining.
//   Throughput is one word per cycle while the receiver does not stall; the
//   filter feedback (previous input and previous filtered value) is held in registers.
//   When the receiver stalls, the output register holds its word and the
//   input register holds the pending word; o_in_stall rises only once both
//   are full, so no word is lost or repeated.
//   Configuration (i_cfg_we / i_cfg_index / i_cfg_wdata) is to be written only while
//   the block is idle; the block does not enforce this. A new warm-up length takes
//   effect at the next restart. Synchronous reset (i_rst_n low) empties both registers,
//   clears the filter taps, peaks and VU level, and loads gain 3 and warm-up length 0.
module mic_dc_block_gain_vu_meter_core
    import mdcvu_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write port
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_index,
    input  logic [CfgDataWidth-1:0] i_cfg_wdata,
    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_word                i_in_word,
    // output channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_word               o_out_word
);

    // configuration
    logic [WarmupWidth-1:0] r_warmup_length;
    logic [GainWidth-1:0]   r_mic_gain;

    // pipeline registers
    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;

    // block state
    logic signed [SampleWidth-1:0] r_prev_in,  n_prev_in;
    logic signed [FiltWidth-1:0]   r_prev_filt, n_prev_filt;
    logic [WarmupWidth-1:0]        r_warmup_left, n_warmup_left;
    logic [PeakWidth-1:0]          r_run_peak, n_run_peak;
    logic [PeakWidth-1:0]          r_pub_peak, n_pub_peak;
    logic [VuWidth-1:0]            r_vu, n_vu;
    t_out_word                     n_out_word;

    // datapath intermediates
    logic signed [28:0]            feed_prod;
    logic signed [28:0]            feed_adj;
    logic signed [FiltWidth-1:0]   feed_q;
    logic signed [FiltWidth+1:0]   filt_sum;
    logic signed [FiltWidth-1:0]   filt_y;
    logic signed [28:0]            gain_prod;
    logic signed [SampleWidth-1:0] sat_g;
    logic [PeakWidth-1:0]          mag;
    logic [PeakWidth-1:0]          peak_now;
    logic [VuWidth-1:0]            vu_cand;

    logic advance;

    // Move the input register forward when the output register is free or draining.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup_length <= '0;
            r_mic_gain      <= GainReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WARMUP_LENGTH: r_warmup_length <= i_cfg_wdata[WarmupWidth-1:0];
                CFG_MIC_GAIN:      r_mic_gain      <= i_cfg_wdata[GainWidth-1:0];
                default:           r_mic_gain      <= r_mic_gain;
            endcase
        end
    end

    // Filter, gain and saturation for the word in the input register.
    always_comb begin
        // (prev_filt * 31) / 32, rounding toward zero: bias negatives before the shift.
        feed_prod = 29'(r_prev_filt) * 29'sd31;
        feed_adj  = feed_prod + (feed_prod[28] ? 29'sd31 : 29'sd0);
        feed_q    = feed_adj[28:5];
        filt_sum  = (FiltWidth+2)'(r_in_word.sample) - (FiltWidth+2)'(r_prev_in)
                  + (FiltWidth+2)'(feed_q);
        filt_y    = filt_sum[FiltWidth-1:0];

        gain_prod = 29'(filt_y) * $signed({25'd0, r_mic_gain});
        if (gain_prod > 29'sd32767) begin
            sat_g = 16'sh7FFF;
        end else if (gain_prod < -29'sd32768) begin
            sat_g = 16'sh8000;
        end else begin
            sat_g = gain_prod[SampleWidth-1:0];
        end

        // Magnitude, with the most negative value taken as full scale.
        if (sat_g == 16'sh8000) begin
            mag = 15'h7FFF;
        end else if (sat_g[SampleWidth-1]) begin
            mag = PeakWidth'(-sat_g);
        end else begin
            mag = sat_g[PeakWidth-1:0];
        end
    end

    // Next state and result word.
    always_comb begin
        n_prev_in     = r_prev_in;
        n_prev_filt   = r_prev_filt;
        n_warmup_left = r_warmup_left;
        n_run_peak    = r_run_peak;
        n_pub_peak    = r_pub_peak;
        n_vu          = r_vu;
        n_out_word    = '0;
        peak_now      = r_run_peak;
        vu_cand       = '0;

        case (r_in_word.operation)
            OP_SAMPLE: begin
                if (r_warmup_left != '0) begin
                    // drop the sample, count down warm-up
                    n_warmup_left = r_warmup_left - 1'b1;
                end else begin
                    n_prev_in   = r_in_word.sample;
                    n_prev_filt = filt_y;
                    n_out_word.sample_valid       = 1'b1;
                    n_out_word.conditioned_sample = sat_g;
                    if (mag > r_run_peak) begin
                        peak_now = mag;
                    end
                end
                n_run_peak = peak_now;
                if (r_in_word.last_in_chunk) begin
                    // publish the chunk peak and raise the meter
                    n_pub_peak = peak_now;
                    n_run_peak = '0;
                    vu_cand    = vu_from_peak(peak_now);
                    if (vu_cand > r_vu) begin
                        n_vu = vu_cand;
                    end
                end
            end
            OP_DECAY: begin
                if (r_vu != '0) begin
                    n_vu = r_vu - 1'b1;
                end
            end
            OP_RESTART: begin
                n_prev_in     = '0;
                n_prev_filt   = '0;
                n_warmup_left = r_warmup_length;
                n_run_peak    = '0;
                n_pub_peak    = '0;
                n_vu          = '0;
            end
            default: begin
                // unused code: no state change
            end
        endcase

        n_out_word.chunk_peak = n_pub_peak;
        n_out_word.vu_level   = n_vu;
    end

    // pipeline control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_prev_in     <= '0;
            r_prev_filt   <= '0;
            r_warmup_left <= '0;
            r_run_peak    <= '0;
            r_pub_peak    <= '0;
            r_vu          <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_prev_in     <= n_prev_in;
                    r_prev_filt   <= n_prev_filt;
                    r_warmup_left <= n_warmup_left;
                    r_run_peak    <= n_run_peak;
                    r_pub_peak    <= n_pub_peak;
                    r_vu          <= n_vu;
                end
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_word <= n_out_word;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

endmodule
